[hw/rtl/worst_fit_block_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Worst-fit block allocator assertion macros
// Shorthand for clocked assertions, reset-gated on arst_n.
// ----------------------------------------------------------------------------
`ifndef WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define WFBA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/wfba_pkg.sv]
// ----------------------------------------------------------------------------
// wfba_pkg
// Shared types and constants of the worst-fit block allocator.
// ----------------------------------------------------------------------------
package wfba_pkg;

	localparam int REQ_BITS = 16;   // amount, size_before, size_left
	localparam int BLK_BITS = 5;    // block_number, chosen_block
	localparam int SUM_BITS = 32;   // leftover_sum
	localparam int CFG_BITS = 6;    // blocks_in_use
	localparam int QDEPTH   = 2;    // front-to-back queue

	localparam logic [CFG_BITS-1:0] BLOCKS_IN_USE_RST = 6'd32;

	// register index, taken from the word address
	localparam logic [0:0] REG_BLOCKS_IN_USE = 1'b0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                load_ok;   // load target lies inside the table
		logic [BLK_BITS-1:0] blk;
		logic [REQ_BITS-1:0] amount;
		logic [CFG_BITS-1:0] n;         // entries to search, already clamped
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_RESULT
	} bk_state_t;

endpackage

[hw/rtl/wfba_ram.sv]
// ----------------------------------------------------------------------------
// wfba_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/wfba_front.sv]
// ----------------------------------------------------------------------------
// wfba_front
// Takes input items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module wfba_front import wfba_pkg::*; #(
	parameter int MAX_BLOCKS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [BLK_BITS-1:0] block_number,
	input  logic [REQ_BITS-1:0] amount,
	input  logic [CFG_BITS-1:0] blocks_in_use,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t            ent_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	cmd_t            cls;
	logic            push;
	logic            pop;

	// classify the incoming item
	always_comb begin
		cls.op      = req_type ? OP_ALLOC : OP_LOAD;
		cls.load_ok = (32'(block_number) < 32'(MAX_BLOCKS));
		cls.blk     = block_number;
		cls.amount  = amount;
		cls.n       = (32'(blocks_in_use) > 32'(MAX_BLOCKS)) ? CFG_BITS'(MAX_BLOCKS)
		                                                     : blocks_in_use;
	end

	assign in_ready  = (count_q != CW'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/wfba_back.sv]
// ----------------------------------------------------------------------------
// wfba_back
// Carries out queued items: table loads and the worst-fit scan and grant.
// ----------------------------------------------------------------------------
`include "worst_fit_block_allocator_macros.svh"

module wfba_back import wfba_pkg::*; #(
	parameter int MAX_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  cmd_t                cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                granted,
	output logic [BLK_BITS-1:0] chosen_block,
	output logic [REQ_BITS-1:0] size_before,
	output logic [REQ_BITS-1:0] size_left,
	output logic [SUM_BITS-1:0] leftover_sum
);

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CW   = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;
	localparam int CNTW = (IW > CFG_BITS) ? IW : CFG_BITS;

	bk_state_t            state_q, state_d;
	cmd_t                 cmd_q;
	logic [IW-1:0]        cnt_q;
	logic                 cmp_vld_s1;
	logic [IW-1:0]        idx_s1;
	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [SUM_BITS-1:0]  leftover_q;
	logic                 out_valid_q;

	logic                 re;
	logic [IW-1:0]        raddr;
	logic [SIZE_BITS-1:0] rdata;
	logic                 we;
	logic [IW-1:0]        waddr;
	logic [SIZE_BITS-1:0] wdata;
	logic                 out_load;
	logic                 last_issue;
	logic                 grant;
	logic [CW-1:0]        best_ext;
	logic [CW-1:0]        left_w;
	logic [SUM_BITS:0]    sum_w;
	logic [SUM_BITS-1:0]  sum_sat;

	wfba_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign last_issue = (CNTW'(cnt_q) == CNTW'(cmd_q.n) - CNTW'(1));
	assign best_ext   = CW'(best_size_q);
	assign grant      = (cmd_q.op == OP_ALLOC) && found_q && (best_ext >= CW'(cmd_q.amount));
	assign left_w     = best_ext - CW'(cmd_q.amount);
	assign sum_w      = {1'b0, leftover_q} + (SUM_BITS + 1)'(left_w);
	assign sum_sat    = sum_w[SUM_BITS] ? '1 : sum_w[SUM_BITS-1:0];

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		re       = 1'b0;
		raddr    = cnt_q;
		we       = 1'b0;
		waddr    = IW'(cmd_q.blk);
		wdata    = SIZE_BITS'(cmd_q.amount);
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_LOAD || cmd.n == '0) begin
						state_d = BK_RESULT;
					end else begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				re = 1'b1;
				if (last_issue) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				// last read data is compared in this cycle
				state_d = BK_RESULT;
			end
			BK_RESULT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
					if (cmd_q.op == OP_LOAD) begin
						we = cmd_q.load_ok;
					end else begin
						we    = grant;
						waddr = best_idx_q;
						wdata = SIZE_BITS'(left_w);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			cmp_vld_s1  <= 1'b0;
			leftover_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= (state_q == BK_SCAN);
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (grant) begin
					leftover_q <= sum_sat;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q   <= cmd;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (state_q == BK_SCAN) begin
			cnt_q <= cnt_q + IW'(1);
		end
		idx_s1 <= cnt_q;
		// running max; strict compare keeps the lowest index on a tie
		if (cmp_vld_s1 && (!found_q || rdata > best_size_q)) begin
			found_q     <= 1'b1;
			best_idx_q  <= idx_s1;
			best_size_q <= rdata;
		end
		if (out_load) begin
			granted      <= grant;
			chosen_block <= grant ? BLK_BITS'(best_idx_q) : '0;
			size_before  <= grant ? REQ_BITS'(best_ext) : '0;
			size_left    <= grant ? REQ_BITS'(left_w) : '0;
			leftover_sum <= grant ? sum_sat : leftover_q;
		end
	end

	assign out_valid = out_valid_q;

	`WFBA_ASSERT(a_scan_in_range, state_q == BK_SCAN, CNTW'(cnt_q) < CNTW'(cmd_q.n), "scan past searched entries")
	`WFBA_ASSERT(a_write_at_result, we, state_q == BK_RESULT, "table written outside result step")
	`WFBA_ASSERT(a_grant_shrinks, out_valid_q && granted, size_left <= size_before, "granted block grew")
	`WFBA_ASSERT_NEXT(a_total_monotonic, 1'b1, leftover_q >= $past(leftover_q), "leftover total decreased")

endmodule

[hw/rtl/worst_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// worst_fit_block_allocator
// Worst-fit allocator over a table of free block sizes, with APB config.
// ----------------------------------------------------------------------------
// A load item goes from the back end's idle step straight to its result step,
// where it writes one table entry. An allocate item searches n entries, n being
// blocks_in_use capped at MAX_BLOCKS: the size table sits in a RAM with one read
// port, so the worst-fit search reads one entry per cycle, followed by a compare
// drain step and a combined write-back/result step. Items enter through a
// two-deep queue, so the input side can take up to two items while the back end
// scans or a result waits on the output register.
module worst_fit_block_allocator import wfba_pkg::*; #(
	parameter int MAX_BLOCKS = 32,
	parameter int SIZE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [BLK_BITS-1:0] block_number,
	input  logic [REQ_BITS-1:0] amount,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                granted,
	output logic [BLK_BITS-1:0] chosen_block,
	output logic [REQ_BITS-1:0] size_before,
	output logic [REQ_BITS-1:0] size_left,
	output logic [SUM_BITS-1:0] leftover_sum
);

	logic [CFG_BITS-1:0] blocks_in_use_q;
	logic                cfg_wr;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCKS_IN_USE);
	assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ? 32'(blocks_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= BLOCKS_IN_USE_RST;
		end else if (cfg_wr) begin
			blocks_in_use_q <= pwdata[CFG_BITS-1:0];
		end
	end

	wfba_front #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.block_number  (block_number),
		.amount        (amount),
		.blocks_in_use (blocks_in_use_q),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop)
	);

	wfba_back #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.granted      (granted),
		.chosen_block (chosen_block),
		.size_before  (size_before),
		.size_left    (size_left),
		.leftover_sum (leftover_sum)
	);

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Worst-fit block allocator testbench. A short directed table comes first,
// then random load/allocate traffic over several search widths, then a few
// zero and boundary requests on a full block. Every result is checked field
// by field against an in-bench worst-fit predictor or its typed table row.
// ----------------------------------------------------------------------------
module tb_top;
	import wfba_pkg::*;

	localparam int NUM_BLOCKS   = 32;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 40;
	localparam int MAX_IDLE     = 8;
	localparam int NUM_PHASES   = 9;
	localparam int RANDOM_WIDTH = -1;
	localparam logic [SUM_BITS-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic                granted;
		logic [BLK_BITS-1:0] chosen;
		logic [REQ_BITS-1:0] sz_before;
		logic [REQ_BITS-1:0] left;
		logic [SUM_BITS-1:0] sum;
	} alloc_result_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// for ROW_CFG rows the register value sits in amt
	typedef struct packed {
		row_kind_t           kind;
		op_t                 op;
		logic [BLK_BITS-1:0] blk;
		logic [REQ_BITS-1:0] amt;
		logic                typed;
		alloc_result_t       res;
	} stim_row_t;

	localparam int DIR_ROWS = 17;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// no entry searched: every allocate is refused
		'{ROW_CFG,  OP_LOAD,  5'd0,  16'd0,     1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd31, 16'd0,     1'b1, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd0,  16'hFFFF,  1'b1, '0},
		'{ROW_ITEM, OP_LOAD,  5'd0,  16'hFFFF,  1'b1, '0},
		'{ROW_ITEM, OP_LOAD,  5'd31, 16'd0,     1'b1, '0},
		'{ROW_ITEM, OP_LOAD,  5'd1,  16'd100,   1'b1, '0},
		// single entry: full-size grant, then a refusal on the emptied block
		'{ROW_CFG,  OP_LOAD,  5'd1,  16'd1,     1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd21, 16'hFFFF,  1'b1,
			'{1'b1, 5'd0, 16'hFFFF, 16'd0, 32'd0}},
		'{ROW_ITEM, OP_ALLOC, 5'd10, 16'd1,     1'b1, '0},
		'{ROW_ITEM, OP_LOAD,  5'd0,  16'hFFFF,  1'b1, '0},
		// zero request keeps the block size
		'{ROW_ITEM, OP_ALLOC, 5'd0,  16'd0,     1'b1,
			'{1'b1, 5'd0, 16'hFFFF, 16'hFFFF, 32'd65535}},
		// two entries: largest wins, tie goes to the lower index
		'{ROW_CFG,  OP_LOAD,  5'd0,  16'd2,     1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd3,  16'd50,    1'b0, '0},
		'{ROW_ITEM, OP_LOAD,  5'd0,  16'd100,   1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd5,  16'd10,    1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd6,  16'd10,    1'b0, '0},
		'{ROW_ITEM, OP_ALLOC, 5'd7,  16'd101,   1'b0, '0}
	};

	localparam int PHASE_CFG [NUM_PHASES] =
		'{32, 63, 0, 1, 17, RANDOM_WIDTH, 40, 32, RANDOM_WIDTH};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic                req_type;
	logic [BLK_BITS-1:0] block_number;
	logic [REQ_BITS-1:0] amount;
	logic                out_valid;
	logic                out_ready;
	logic                granted;
	logic [BLK_BITS-1:0] chosen_block;
	logic [REQ_BITS-1:0] size_before;
	logic [REQ_BITS-1:0] size_left;
	logic [SUM_BITS-1:0] leftover_sum;

	// predictor state
	logic [REQ_BITS-1:0] free_sz [NUM_BLOCKS];
	logic [SUM_BITS-1:0] total_left;
	logic [CFG_BITS-1:0] search_cnt;

	alloc_result_t pending_results [$];
	bit            idle_on;
	int            errors;

	worst_fit_block_allocator uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_draw();
		return idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
	endfunction

	function automatic alloc_result_t worst_fit_predict(op_t op, logic [BLK_BITS-1:0] blk,
			logic [REQ_BITS-1:0] amt);
		alloc_result_t       r;
		int                  n;
		int                  k;
		int                  best_idx;
		logic [REQ_BITS-1:0] best_sz;
		logic [SUM_BITS:0]   acc;
		r = '0;
		if (op == OP_LOAD) begin
			free_sz[blk] = amt;
		end else begin
			n = (int'(search_cnt) > NUM_BLOCKS) ? NUM_BLOCKS : int'(search_cnt);
			best_idx = 0;
			best_sz = '0;
			for (k = 0; k < n; k++) begin
				if (k == 0 || free_sz[k] > best_sz) begin
					best_idx = k;
					best_sz = free_sz[k];
				end
			end
			if (n > 0 && best_sz >= amt) begin
				r.granted = 1'b1;
				r.chosen = best_idx[BLK_BITS-1:0];
				r.sz_before = best_sz;
				r.left = best_sz - amt;
				free_sz[best_idx] = r.left;
				acc = {1'b0, total_left} + {{(SUM_BITS + 1 - REQ_BITS){1'b0}}, r.left};
				total_left = acc[SUM_BITS] ? TOTAL_MAX : acc[SUM_BITS-1:0];
			end
		end
		r.sum = total_left;
		return r;
	endfunction

	task automatic send_item(op_t op, logic [BLK_BITS-1:0] blk, logic [REQ_BITS-1:0] amt,
			logic typed, alloc_result_t typed_res);
		int            gap;
		alloc_result_t r;
		gap = idle_draw();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= op;
		block_number <= blk;
		amount <= amt;
		do @(posedge clk); while (!in_ready);
		r = worst_fit_predict(op, blk, amt);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	// only while the allocator is idle: every item leaves exactly one result
	task automatic write_blocks_in_use(logic [CFG_BITS-1:0] val);
		logic [31:0] rnd;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		rnd = $urandom();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_BLOCKS_IN_USE, 2'b00};
		pwdata <= {rnd[31:CFG_BITS], val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		search_cnt = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random_item();
		op_t                 op;
		logic [31:0]         rnd;
		logic [31:0]         small_amt;
		logic [REQ_BITS-1:0] amt;
		int                  pick;
		rnd = $urandom();
		small_amt = $urandom_range(0, 8191);
		pick = $urandom_range(0, 9);
		op = ($urandom_range(0, 9) < 4) ? OP_LOAD : OP_ALLOC;
		if (pick == 0)
			amt = '0;
		else if (pick == 1)
			amt = '1;
		else if (op == OP_LOAD || pick < 4)
			amt = rnd[REQ_BITS-1:0];
		else
			amt = small_amt[REQ_BITS-1:0];
		send_item(op, rnd[REQ_BITS+BLK_BITS-1:REQ_BITS], amt, 1'b0, '0);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		alloc_result_t e;
		int            stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			out_ready <= (stall == 0);
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result item with no expectation pending");
					errors++;
				end else begin
					e = pending_results.pop_front();
					check_field("granted", 32'(e.granted), 32'(granted));
					check_field("chosen_block", 32'(e.chosen), 32'(chosen_block));
					check_field("size_before", 32'(e.sz_before), 32'(size_before));
					check_field("size_left", 32'(e.left), 32'(size_left));
					check_field("leftover_sum", e.sum, leftover_sum);
				end
				stall = idle_draw();
			end else if (stall > 0) begin
				stall--;
			end
		end
	end

	initial begin
		int          cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		int          i;
		int          p;
		int          val;
		logic [31:0] rnd;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		req_type = 1'b0;
		block_number = '0;
		amount = '0;
		idle_on = 1'b1;
		errors = 0;
		for (i = 0; i < NUM_BLOCKS; i++)
			free_sz[i] = '0;
		total_left = '0;
		search_cnt = BLOCKS_IN_USE_RST;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TABLE[i].kind == ROW_CFG)
				write_blocks_in_use(DIR_TABLE[i].amt[CFG_BITS-1:0]);
			else
				send_item(DIR_TABLE[i].op, DIR_TABLE[i].blk, DIR_TABLE[i].amt,
					DIR_TABLE[i].typed, DIR_TABLE[i].res);
		end

		// load every entry before any wide search
		for (i = 0; i < NUM_BLOCKS; i++) begin
			rnd = $urandom();
			send_item(OP_LOAD, i[BLK_BITS-1:0], rnd[REQ_BITS-1:0], 1'b0, '0);
		end

		for (p = 0; p < NUM_PHASES; p++) begin
			val = (PHASE_CFG[p] == RANDOM_WIDTH) ? int'($urandom_range(1, NUM_BLOCKS))
				: PHASE_CFG[p];
			idle_on = (p != 6);
			write_blocks_in_use(val[CFG_BITS-1:0]);
			repeat ((val == 0) ? 20 : 40) send_random_item();
		end

		// zero and boundary requests on a full block
		idle_on = 1'b0;
		write_blocks_in_use(6'd1);
		send_item(OP_LOAD, 5'd0, 16'hFFFF, 1'b0, '0);
		repeat (4) begin
			rnd = $urandom();
			send_item(OP_ALLOC, rnd[BLK_BITS-1:0], 16'd0, 1'b0, '0);
		end
		send_item(OP_ALLOC, 5'd0, 16'd0, 1'b0, '0);
		send_item(OP_ALLOC, 5'd31, 16'hFFFF, 1'b0, '0);
		send_item(OP_ALLOC, 5'd0, 16'd1, 1'b0, '0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/wfba_pkg.sv
hw/rtl/wfba_ram.sv
hw/rtl/wfba_front.sv
hw/rtl/wfba_back.sv
hw/rtl/worst_fit_block_allocator.sv
tb/sv/tb_top.sv
